// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the dither block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, silenced during reset.
`define SEDD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, silenced during reset.
`define SEDD_ASSERT_NXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/sedd_pkg.sv -----
package sedd_pkg;

  localparam int MaxWidth = 1024;
  localparam int XW       = 10;
  localparam int ErrW     = 18;
  localparam int TagW     = 16;
  localparam int MemAw    = XW + 1;
  localparam int MemDw    = TagW + ErrW;
  localparam int FifoDepth = 2;

  localparam logic [1:0] RegImageWidth  = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;
  localparam logic [1:0] RegThreshold   = 2'd2;

  localparam logic signed [ErrW-1:0] ErrMax = 18'sh1FFFF;
  localparam logic signed [ErrW-1:0] ErrMin = 18'sh20000;

  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [10:0] width;
    logic [15:0] height;
    logic [15:0] thr;
  } cfg_t;

  function automatic logic signed [ErrW-1:0] sat18(input logic signed [20:0] v);
    logic signed [ErrW-1:0] r;
    if (v > 21'(ErrMax)) r = ErrMax;
    else if (v < 21'(ErrMin)) r = ErrMin;
    else r = v[ErrW-1:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/serpentine_error_diffusion_dither_top.sv -----
// The front accepts a new pixel only when it is idle: its unpremultiply
// divider runs in the front (accept, 16 divide steps, multiply, sum); the back
// error loop then reads, does 3 read-modify-writes and registers the output.
// Reset is asynchronous, active low; after it a clearing pass runs over all
// 2048 words of the error memory, during which input is stalled.
`include "assert_macros.svh"

module serpentine_error_diffusion_dither_top import sedd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  level_out_o,
  output logic [7:0]  alpha_out_o,
  output logic        last_of_image_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic clearing, push, pop, full, empty;
  pix_t push_data, pop_data;

  // register file: a write lands in the access phase
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 11'd1024;
      cfg_q.height <= 16'd1;
      cfg_q.thr    <= 16'd32640;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegImageWidth:  cfg_q.width  <= pwdata[10:0];
        RegImageHeight: cfg_q.height <= pwdata[15:0];
        RegThreshold:   cfg_q.thr    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegImageWidth:  prdata = {21'd0, cfg_q.width};
      RegImageHeight: prdata = {16'd0, cfg_q.height};
      RegThreshold:   prdata = {16'd0, cfg_q.thr};
      default:        prdata = '0;
    endcase
  end

  // front: unpremultiply and luma; holds off input while memory clears
  sedd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .alpha_in_i  (alpha_in_i),
    .hold_i      (clearing),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // two-word queue between gray producer and error loop
  sedd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // back: error diffusion against the row-error memory, output register
  sedd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .pix_i           (pop_data),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .level_out_o     (level_out_o),
    .alpha_out_o     (alpha_out_o),
    .last_of_image_o (last_of_image_o)
  );

  `SEDD_ASSERT_IMP(a_level_binary, clk_i, rst_ni, out_valid_o, (level_out_o == 8'd0 || level_out_o == 8'd255))
  `SEDD_ASSERT_IMP(a_no_input_while_clearing, clk_i, rst_ni, clearing, in_stall_o)
  `SEDD_ASSERT_IMP(a_no_push_when_full, clk_i, rst_ni, full, !push)

endmodule

// ----- hw/rtl/sedd_front.sv -----
module sedd_front import sedd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_in_i,
  input  logic       hold_i,
  input  logic       full_i,
  output logic       push_o,
  output pix_t       push_data_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_MUL  = 2'd2;
  localparam logic [1:0] F_SUM  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  a_q, a_d;
  logic [7:0]  c_q   [3], c_d   [3];
  logic [15:0] n_q   [3], n_d   [3];
  logic [7:0]  rem_q [3], rem_d [3];
  logic [7:0]  quo_q [3], quo_d [3];
  logic [23:0] prod_q [3], prod_d [3];
  logic [23:0] sum;
  logic        accept;
  logic [7:0]  cin [3];
  logic [8:0]  t;
  logic [7:0]  u;

  assign in_stall_o = (state_q != F_IDLE) || hold_i;
  assign accept = in_valid_i && !in_stall_o;
  assign cin[0] = red_in_i;
  assign cin[1] = green_in_i;
  assign cin[2] = blue_in_i;
  assign sum = prod_q[0] + prod_q[1] + prod_q[2];
  assign push_data_o.gray  = sum[23:16];
  assign push_data_o.alpha = a_q;
  assign push_o = (state_q == F_SUM) && !full_i;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    a_d = a_q;
    t = '0;
    u = '0;
    for (int i = 0; i < 3; i++) begin
      c_d[i] = c_q[i];
      n_d[i] = n_q[i];
      rem_d[i] = rem_q[i];
      quo_d[i] = quo_q[i];
      prod_d[i] = prod_q[i];
    end
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          a_d = alpha_in_i;
          for (int i = 0; i < 3; i++) begin
            c_d[i] = cin[i];
            n_d[i] = {cin[i], 8'd0} - {8'd0, cin[i]};
            rem_d[i] = '0;
            quo_d[i] = '0;
          end
          cnt_d = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // restoring divide, one quotient bit per cycle in each lane
        for (int i = 0; i < 3; i++) begin
          t = {rem_q[i], n_q[i][15]};
          if (t >= {1'b0, a_q}) begin
            u = 8'(t - {1'b0, a_q});
            rem_d[i] = u;
            quo_d[i] = {quo_q[i][6:0], 1'b1};
          end else begin
            rem_d[i] = t[7:0];
            quo_d[i] = {quo_q[i][6:0], 1'b0};
          end
          n_d[i] = {n_q[i][14:0], 1'b0};
        end
        // all 16 numerator bits pass through; c < alpha keeps the quotient in 8 bits
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = F_MUL;
      end
      F_MUL: begin
        for (int i = 0; i < 3; i++) begin
          if (a_q == '0) quo_d[i] = '0;
          else if (c_q[i] >= a_q) quo_d[i] = 8'd255;
        end
        prod_d[0] = 24'd19595 * 24'((a_q == '0) ? 8'd0 :
                    (c_q[0] >= a_q) ? 8'd255 : quo_q[0]);
        prod_d[1] = 24'd38470 * 24'((a_q == '0) ? 8'd0 :
                    (c_q[1] >= a_q) ? 8'd255 : quo_q[1]);
        prod_d[2] = 24'd7471 * 24'((a_q == '0) ? 8'd0 :
                    (c_q[2] >= a_q) ? 8'd255 : quo_q[2]);
        state_d = F_SUM;
      end
      F_SUM: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    for (int i = 0; i < 3; i++) begin
      c_q[i] <= c_d[i];
      n_q[i] <= n_d[i];
      rem_q[i] <= rem_d[i];
      quo_q[i] <= quo_d[i];
      prod_q[i] <= prod_d[i];
    end
  end

endmodule

// ----- hw/rtl/sedd_fifo.sv -----
module sedd_fifo import sedd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t push_data_i,
  input  logic pop_i,
  output pix_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  pix_t       mem_q [FifoDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule

// ----- hw/rtl/sedd_back.sv -----
module sedd_back import sedd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       empty_i,
  input  pix_t       pix_i,
  output logic       pop_o,
  output logic       clearing_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] level_out_o,
  output logic [7:0] alpha_out_o,
  output logic       last_of_image_o
);

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RDV  = 3'd2;
  localparam logic [2:0] B_WX   = 3'd3;
  localparam logic [2:0] B_WB   = 3'd4;
  localparam logic [2:0] B_WA   = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [MemAw-1:0] clr_q, clr_d;
  logic [XW-1:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [TagW-1:0] gen_q, gen_d, gen_nx;
  logic signed [ErrW-1:0] fwd_q, fwd_d, e_q, e_d;
  pix_t        pix_q, pix_d;
  logic [XW-1:0] x_q, x_d, beh_q, beh_d, ahd_q, ahd_d, col_c_q, col_c_d;
  logic        lc_q, lc_d, lr_q, lr_d, hb_q, hb_d, lvl_q, lvl_d;
  logic        ov_q, ov_d, olast_q, olast_d;
  logic [7:0]  olvl_q, olvl_d, oa_q, oa_d;

  logic [MemDw-1:0] mem [2**MemAw];
  logic [MemDw-1:0] rd_q, wdata;
  logic [MemAw-1:0] raddr, waddr;
  logic        we;

  // geometry for the word at the queue head
  logic [10:0] w_eff, wm1;
  logic [15:0] h_eff;
  logic [XW-1:0] col, x;
  logic        odd;

  logic signed [ErrW-1:0] cur_err, nxt_old, s_sel;
  logic signed [20:0] vsum, vsub, e7, e5, e3, sh7, sh5, sh3;
  logic signed [ErrW-1:0] v;

  assign w_eff = (cfg_i.width == '0) ? 11'd1 :
                 (cfg_i.width > 11'(MaxWidth)) ? 11'(MaxWidth) : cfg_i.width;
  assign h_eff = (cfg_i.height == '0) ? 16'd1 : cfg_i.height;
  assign wm1   = w_eff - 11'd1;
  assign col   = ({1'b0, col_q} >= w_eff) ? wm1[XW-1:0] : col_q;
  assign odd   = row_q[0];
  assign x     = odd ? XW'(wm1[XW-1:0] - col) : col;
  assign gen_nx = gen_q + 1'b1;

  // stored errors count only when their row tag is current
  assign cur_err = (rd_q[MemDw-1 -: TagW] == gen_q) ? rd_q[ErrW-1:0] : '0;
  assign nxt_old = (rd_q[MemDw-1 -: TagW] == gen_nx) ? rd_q[ErrW-1:0] : '0;

  assign vsum = 21'({pix_q.gray, 8'd0}) + 21'(cur_err) + 21'(fwd_q);
  assign v    = sat18(vsum);
  assign vsub = 21'(v) - 21'sd65280;

  assign e7  = (21'(e_q) <<< 3) - 21'(e_q);
  assign e5  = (21'(e_q) <<< 2) + 21'(e_q);
  assign e3  = (21'(e_q) <<< 1) + 21'(e_q);
  assign sh7 = e7 >>> 4;
  assign sh5 = e5 >>> 4;
  assign sh3 = e3 >>> 4;

  assign clearing_o = (state_q == B_CLR);
  assign pop_o = (state_q == B_IDLE) && !empty_i;
  assign out_valid_o = ov_q;
  assign level_out_o = olvl_q;
  assign alpha_out_o = oa_q;
  assign last_of_image_o = olast_q;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    col_d = col_q;
    row_d = row_q;
    gen_d = gen_q;
    fwd_d = fwd_q;
    e_d = e_q;
    pix_d = pix_q;
    x_d = x_q;
    beh_d = beh_q;
    ahd_d = ahd_q;
    col_c_d = col_c_q;
    lc_d = lc_q;
    lr_d = lr_q;
    hb_d = hb_q;
    lvl_d = lvl_q;
    ov_d = ov_q;
    olvl_d = olvl_q;
    oa_d = oa_q;
    olast_d = olast_q;
    raddr = {gen_q[0], x_q};
    waddr = {~gen_q[0], x_q};
    we = 1'b0;
    s_sel = '0;
    wdata = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      B_CLR: begin
        we = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!empty_i) begin
          pix_d = pix_i;
          col_c_d = col;
          x_d = x;
          beh_d = odd ? XW'(x + 1'b1) : XW'(x - 1'b1);
          ahd_d = odd ? XW'(x - 1'b1) : XW'(x + 1'b1);
          lc_d = ({1'b0, col} + 11'd1) >= w_eff;
          lr_d = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
          hb_d = (col != '0);
          raddr = {gen_q[0], x};
          state_d = B_RDV;
        end
      end
      B_RDV: begin
        if (v < $signed({2'b00, cfg_i.thr})) begin
          lvl_d = 1'b0;
          e_d = v;
        end else begin
          lvl_d = 1'b1;
          e_d = sat18(vsub);
        end
        raddr = {~gen_q[0], x_q};
        state_d = B_WX;
      end
      B_WX: begin
        s_sel = sh5[ErrW-1:0];
        we = !lr_q;
        waddr = {~gen_q[0], x_q};
        wdata = {gen_nx, sat18(21'(nxt_old) + 21'(s_sel))};
        raddr = {~gen_q[0], beh_q};
        state_d = B_WB;
      end
      B_WB: begin
        s_sel = sh3[ErrW-1:0];
        we = !lr_q && hb_q;
        waddr = {~gen_q[0], beh_q};
        wdata = {gen_nx, sat18(21'(nxt_old) + 21'(s_sel))};
        raddr = {~gen_q[0], ahd_q};
        state_d = B_WA;
      end
      B_WA: begin
        // one sixteenth: the share is e itself shifted down
        s_sel = ErrW'(21'(e_q) >>> 4);
        we = !lr_q && !lc_q;
        waddr = {~gen_q[0], ahd_q};
        wdata = {gen_nx, sat18(21'(nxt_old) + 21'(s_sel))};
        state_d = B_OUT;
      end
      B_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          olvl_d = lvl_q ? 8'd255 : 8'd0;
          oa_d = pix_q.alpha;
          olast_d = lc_q && lr_q;
          if (lc_q) begin
            col_d = '0;
            fwd_d = '0;
            // image end steps two tags so a half-written next row reads as zero
            gen_d = lr_q ? gen_q + 16'd2 : gen_nx;
            row_d = lr_q ? 16'd0 : row_q + 16'd1;
          end else begin
            col_d = col_c_q + 1'b1;
            fwd_d = sh7[ErrW-1:0];
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLR;
      clr_q <= '0;
      col_q <= '0;
      row_q <= '0;
      gen_q <= '0;
      fwd_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      col_q <= col_d;
      row_q <= row_d;
      gen_q <= gen_d;
      fwd_q <= fwd_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    pix_q <= pix_d;
    x_q <= x_d;
    beh_q <= beh_d;
    ahd_q <= ahd_d;
    col_c_q <= col_c_d;
    lc_q <= lc_d;
    lr_q <= lr_d;
    hb_q <= hb_d;
    lvl_q <= lvl_d;
    olvl_q <= olvl_d;
    oa_q <= oa_d;
    olast_q <= olast_d;
  end

endmodule
